FILE: hdl/ast_pkg.sv
// ----------------------------------------------------------------------------
// ast_pkg - shared types and constants of the assembly source tokenizer
// Scan modes, token kind codes, character codes and character class helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package ast_pkg;

	typedef enum logic [3:0] {
		M_IDLE, M_WORD, M_NUMBER, M_COMMENT, M_STRING, M_DIRECTIVE, M_DOT_PEND,
		M_AT_PEND, M_AT_WORD, M_PCT_PEND, M_PCT_WORD, M_HASH_PEND, M_HASH_WORD
	} mode_t;

	localparam logic [3:0] K_NEWLINE   = 4'd0;
	localparam logic [3:0] K_SEPARATOR = 4'd1;
	localparam logic [3:0] K_WORD      = 4'd2;
	localparam logic [3:0] K_REFERENCE = 4'd3;
	localparam logic [3:0] K_NUMBER    = 4'd4;
	localparam logic [3:0] K_COMMENT   = 4'd5;
	localparam logic [3:0] K_STRING    = 4'd6;
	localparam logic [3:0] K_SYMBOL    = 4'd7;
	localparam logic [3:0] K_COLON     = 4'd8;
	localparam logic [3:0] K_COMMA     = 4'd9;
	localparam logic [3:0] K_DOT       = 4'd10;
	localparam logic [3:0] K_DIRECTIVE = 4'd11;
	localparam logic [3:0] K_PERCENT   = 4'd12;
	localparam logic [3:0] K_END       = 4'd13;
	localparam logic [3:0] K_UNKNOWN   = 4'd14;

	localparam logic [7:0] C_EOS   = 8'h00;
	localparam logic [7:0] C_NL    = 8'h0a;
	localparam logic [7:0] C_UNDER = 8'h5f;
	localparam logic [7:0] C_MINUS = 8'h2d;
	localparam logic [7:0] C_SEMI  = 8'h3b;
	localparam logic [7:0] C_COLON = 8'h3a;
	localparam logic [7:0] C_COMMA = 8'h2c;
	localparam logic [7:0] C_DOT   = 8'h2e;
	localparam logic [7:0] C_AT    = 8'h40;
	localparam logic [7:0] C_PCT   = 8'h25;
	localparam logic [7:0] C_HASH  = 8'h23;
	localparam logic [7:0] C_X     = 8'h78;
	localparam logic [7:0] C_QUOTE = 8'h22;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_wordc(input logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == C_UNDER;
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
	endfunction

	function automatic logic is_symbol(input logic [7:0] c);
		return c == 8'h5b || c == 8'h5d || c == 8'h28 || c == 8'h29 || c == 8'h2b ||
			c == 8'h7b || c == 8'h7d;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/ast_front.sv
// ----------------------------------------------------------------------------
// ast_front - scanner front end
// Accepts one source byte per cycle while take is high, updates the scan state
// and classifies the byte into zero, one or two result records for the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module ast_front #(
	parameter int OFFSET_BITS = 20,
	parameter int LINE_BITS = 16,
	localparam int RW = 4 + 2 * OFFSET_BITS + 1 + 2 * LINE_BITS + 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire logic [7:0]    b,
	output logic               v0,
	output logic               v1,
	output logic [RW-1:0]      r0,
	output logic [RW-1:0]      r1
);
	import ast_pkg::*;

	localparam int OB = OFFSET_BITS;
	localparam int LB = LINE_BITS;

	mode_t           mode_q, nmode;
	logic [OB-1:0]   start_q, nstart, pos_q, npos, pos_adv;
	logic [LB-1:0]   line_q, nline, line_adv, col_q, ncol, col_adv, pcol_q, npcol;
	logic            sep_q, nsep;

	logic            va, vb, cont;
	logic [3:0]      ka, kb;
	logic [OB-1:0]   sa, sb;
	logic [OB:0]     ea, eb;
	logic [LB-1:0]   ca, cb, le;

	function automatic logic [RW-1:0] pack(input logic [3:0] k, input logic [OB-1:0] s,
		input logic [OB:0] e, input logic [LB-1:0] l, input logic [LB-1:0] c,
		input logic last);
		return {k, s, e, l, c, last};
	endfunction

	always_comb begin
		pos_adv  = (&pos_q) ? pos_q : pos_q + 1'b1;
		line_adv = (b == C_NL) ? ((&line_q) ? line_q : line_q + 1'b1) : line_q;
		col_adv  = (b == C_NL) ? '0 : ((&col_q) ? col_q : col_q + 1'b1);

		nmode = mode_q; nstart = start_q; npos = pos_q; nline = line_q; ncol = col_q;
		nsep = sep_q; npcol = pcol_q;
		va = 1'b0; vb = 1'b0; cont = 1'b0;
		ka = K_WORD; sa = start_q; ea = {1'b0, pos_q}; ca = col_q;
		kb = K_UNKNOWN; sb = pos_q; eb = {1'b0, pos_q} + 1'b1; cb = col_q;
		le = line_q;

		// continuation test for open tokens
		unique case (mode_q)
			M_WORD, M_DIRECTIVE, M_AT_WORD, M_PCT_WORD: cont = is_wordc(b);
			M_NUMBER: cont = is_xdigit(b) || b == C_X;
			M_HASH_WORD: cont = is_digit(b);
			M_COMMENT: cont = (b != C_NL);
			M_DOT_PEND: if (is_alpha(b)) begin nmode = M_DIRECTIVE; cont = 1'b1; end
			M_AT_PEND: if (is_alpha(b)) begin nmode = M_AT_WORD; cont = 1'b1; end
			M_PCT_PEND: if (is_alpha(b)) begin nmode = M_PCT_WORD; cont = 1'b1; end
			M_HASH_PEND: if (is_digit(b)) begin nmode = M_HASH_WORD; cont = 1'b1; end
			default: cont = 1'b0;
		endcase

		if (b == C_EOS || !(cont || mode_q == M_STRING)) begin
			// close the open token
			va = 1'b1;
			unique case (mode_q)
				M_WORD: ka = (b == C_COLON) ? K_REFERENCE : K_WORD;
				M_NUMBER: ka = K_NUMBER;
				M_COMMENT: ka = K_COMMENT;
				M_STRING: ka = K_STRING;
				M_DIRECTIVE: ka = K_DIRECTIVE;
				M_AT_WORD, M_HASH_WORD: ka = K_WORD;
				M_PCT_WORD: ka = K_PERCENT;
				M_DOT_PEND: begin
					ka = K_DOT; ea = {1'b0, start_q} + 1'b1; ca = '0;
				end
				M_AT_PEND, M_PCT_PEND, M_HASH_PEND: begin
					ka = K_UNKNOWN; ea = {1'b0, start_q} + 1'b1; ca = pcol_q;
				end
				default: va = 1'b0;
			endcase
			if (mode_q != M_IDLE) nsep = 1'b0;
			nmode = M_IDLE;
		end

		if (b == C_EOS) begin
			vb = 1'b1; kb = K_END; eb = {1'b0, pos_q};
			nmode = M_IDLE; nstart = '0; npos = '0; nline = LB'(1); ncol = '0;
			nsep = 1'b0; npcol = '0;
		end else if (mode_q == M_STRING) begin
			npos = pos_adv; nline = line_adv; ncol = col_adv;
			if (b == C_QUOTE) begin
				va = 1'b1; ka = K_STRING; sa = start_q; ea = {1'b0, pos_adv};
				ca = col_adv; le = line_adv; nmode = M_IDLE; nsep = 1'b0;
			end
		end else if (cont) begin
			npos = pos_adv; nline = line_adv; ncol = col_adv;
		end else begin
			npos = pos_adv; nline = line_adv; ncol = col_adv;
			priority if (b == C_NL) begin
				vb = 1'b1; kb = K_NEWLINE;
			end else if (is_space(b)) begin
				if (!nsep) begin
					nsep = 1'b1; vb = 1'b1; kb = K_SEPARATOR;
				end
			end else if (is_alpha(b) || b == C_UNDER) begin
				nmode = M_WORD; nstart = pos_q; npcol = col_q;
			end else if (is_digit(b) || b == C_MINUS) begin
				nmode = M_NUMBER; nstart = pos_q; npcol = col_q;
			end else if (b == C_SEMI) begin
				nmode = M_COMMENT; nstart = pos_q; npcol = col_q;
			end else if (b == C_QUOTE) begin
				nmode = M_STRING; nstart = pos_q; npcol = col_q;
			end else if (is_symbol(b)) begin
				vb = 1'b1; kb = K_SYMBOL;
			end else if (b == C_COLON) begin
				vb = 1'b1; kb = K_COLON; nsep = 1'b0;
			end else if (b == C_COMMA) begin
				vb = 1'b1; kb = K_COMMA; nsep = 1'b1;
			end else if (b == C_DOT) begin
				if (col_q == '0) begin
					nmode = M_DOT_PEND; nstart = pos_q; npcol = col_q;
				end else begin
					vb = 1'b1; kb = K_DOT;
				end
				nsep = 1'b0;
			end else if (b == C_AT) begin
				nmode = M_AT_PEND; nstart = pos_q; npcol = col_q; nsep = 1'b0;
			end else if (b == C_PCT) begin
				nmode = M_PCT_PEND; nstart = pos_q; npcol = col_q; nsep = 1'b0;
			end else if (b == C_HASH) begin
				nmode = M_HASH_PEND; nstart = pos_q; npcol = col_q; nsep = 1'b0;
			end else begin
				vb = 1'b1; kb = K_UNKNOWN; nsep = 1'b0;
			end
		end

		// pack into queue slots, last flag on the final record of this byte
		v0 = take && (va || vb);
		v1 = take && va && vb;
		if (va)
			r0 = pack(ka, sa, ea, le, ca, !vb);
		else
			r0 = pack(kb, sb, eb, le, cb, 1'b1);
		r1 = pack(kb, sb, eb, le, cb, 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; start_q <= '0; pos_q <= '0; line_q <= LB'(1);
			col_q <= '0; sep_q <= 1'b0; pcol_q <= '0;
		end else if (take) begin
			mode_q <= nmode; start_q <= nstart; pos_q <= npos; line_q <= nline;
			col_q <= ncol; sep_q <= nsep; pcol_q <= npcol;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/ast_queue.sv
// ----------------------------------------------------------------------------
// ast_queue - result queue
// Four-entry queue: takes up to two records a cycle, hands out one on pop.
// ----------------------------------------------------------------------------
`default_nettype none
module ast_queue #(
	parameter int RW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          v0,
	input  wire logic          v1,
	input  wire logic [RW-1:0] r0,
	input  wire logic [RW-1:0] r1,
	output logic               room2,
	output logic               nonempty,
	input  wire logic          pop,
	output logic [RW-1:0]      head
);
	logic [RW-1:0] mem_q [4];
	logic [1:0]    wr_q, rd_q;
	logic [2:0]    cnt_q;
	logic          do_pop;

	assign room2    = cnt_q <= 3'd2;
	assign nonempty = cnt_q != 3'd0;
	assign head     = mem_q[rd_q];
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk) begin
		if (v0) mem_q[wr_q] <= r0;
		if (v1) mem_q[wr_q + 2'd1] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + {1'b0, v0} + {1'b0, v1};
			rd_q  <= rd_q + {1'b0, do_pop};
			cnt_q <= cnt_q + {2'b0, v0} + {2'b0, v1} - {2'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

FILE: hdl/ast_back.sv
// ----------------------------------------------------------------------------
// ast_back - output stage
// Output register that draws records from the queue and holds them while
// the receiver stalls.
// ----------------------------------------------------------------------------
`default_nettype none
module ast_back #(
	parameter int RW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          nonempty,
	input  wire logic [RW-1:0] head,
	output logic               pop,
	input  wire logic          out_stall,
	output logic               out_valid,
	output logic [RW-1:0]      rec
);
	logic          valid_q;
	logic [RW-1:0] rec_q;

	assign pop       = nonempty && (!valid_q || !out_stall);
	assign out_valid = valid_q;
	assign rec       = rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || !out_stall) begin
			valid_q <= nonempty;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) rec_q <= head;
	end

endmodule
`default_nettype wire

FILE: hdl/assembly_source_tokenizer.sv
// ----------------------------------------------------------------------------
// assembly_source_tokenizer - streaming lexer for assembly source
// Cuts a byte stream into tokens with kind, offsets, line, column and file.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | direction
//  ---------+------------------------------------------+----------
//  input    | in_valid, in_stall, source_byte          | in
//  output   | out_valid, out_stall, token fields       | out
//  config   | file_number_we, file_number              | in
//
// one byte is taken per cycle while in_stall is low; scan state is registered.
// a byte gives up to two tokens; the output drains one token per cycle while
// out_stall is low, and a four-entry queue absorbs the surplus.
// in_stall rises when the queue has room for fewer than two tokens.
// reset is asynchronous and clears the scan state and the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module assembly_source_tokenizer #(
	parameter int OFFSET_BITS = 20,
	parameter int LINE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   file_number_we,
	input  wire logic [15:0]            file_number,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic [7:0]             source_byte,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [3:0]                  token_kind,
	output logic [OFFSET_BITS-1:0]      start_offset,
	output logic [OFFSET_BITS:0]        end_offset,
	output logic [LINE_BITS-1:0]        line_number,
	output logic [LINE_BITS-1:0]        column_number,
	output logic [15:0]                 file_tag,
	output logic                        last_of_run
);
	localparam int RW = 4 + 2 * OFFSET_BITS + 1 + 2 * LINE_BITS + 1;

	logic          take, v0, v1, room2, nonempty, pop;
	logic [RW-1:0] r0, r1, head, rec;
	logic [15:0]   file_q;

	assign in_stall = !room2;
	assign take     = in_valid && room2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) file_q <= '0;
		else if (file_number_we) file_q <= file_number;
	end

	ast_front #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .b(source_byte),
		.v0(v0), .v1(v1), .r0(r0), .r1(r1)
	);

	ast_queue #(.RW(RW)) u_queue (
		.clk(clk), .arst_n(arst_n), .v0(v0), .v1(v1), .r0(r0), .r1(r1),
		.room2(room2), .nonempty(nonempty), .pop(pop), .head(head)
	);

	ast_back #(.RW(RW)) u_back (
		.clk(clk), .arst_n(arst_n), .nonempty(nonempty), .head(head), .pop(pop),
		.out_stall(out_stall), .out_valid(out_valid), .rec(rec)
	);

	assign {token_kind, start_offset, end_offset, line_number, column_number,
		last_of_run} = rec;
	assign file_tag = file_q;

endmodule
`default_nettype wire
